// ----- src/rrfp_pkg.sv -----
// Shared types and constants for the rangefinder reply frame parser.
// Used by the front parser, the record queue, the back decoder and the top level.
// Depends on nothing else.
package rrfp_pkg;

    localparam logic [7:0]  HDR0_BYTE      = 8'hEE;
    localparam logic [7:0]  HDR1_BYTE      = 8'h16;
    localparam logic [7:0]  DEVICE_CODE    = 8'h03;
    localparam logic [7:0]  CMD_SELF_TEST  = 8'h01;
    localparam logic [7:0]  CMD_MEASURE    = 8'h02;
    localparam logic [7:0]  CMD_CONTINUOUS = 8'h04;
    localparam logic [7:0]  NIBBLE_MASK    = 8'h0F;
    localparam logic [3:0]  NIB_FIRST      = 4'd1;
    localparam logic [3:0]  NIB_LAST       = 4'd2;
    localparam logic [15:0] METERS_INVALID = 16'hFFFF;
    localparam logic [9:0]  MM_PER_METER   = 10'd1000;
    localparam logic [6:0]  MM_PER_TENTH   = 7'd100;

    localparam int HEAD_BYTES = 6;
    localparam int Q_DEPTH    = 2;
    localparam int DIST_W     = 26;
    localparam int OUT_TDATA_W = 88;

    // Frame record handed from the parser to the decoder: payload bytes one
    // to five and whether the payload held at least six bytes.
    typedef struct packed {
        logic       is_long;
        logic [7:0] b5;
        logic [7:0] b4;
        logic [7:0] b3;
        logic [7:0] b2;
        logic [7:0] cmd;
    } t_frame_rec;

    // Decoded result, reply_command in the lowest bits.
    typedef struct packed {
        logic              continuous_mode;
        logic [DIST_W-1:0] dist_mm;
        logic              last_target_ok;
        logic              first_target_ok;
        logic              target_ok;
        logic [3:0]        target_number;
        logic              self_test_pass;
        logic [31:0]       self_status_word;
        logic [7:0]        status_byte;
        logic              data_valid;
        logic [7:0]        reply_command;
    } t_result;

    // Push side of the record queue.
    typedef struct packed {
        logic       push;
        t_frame_rec rec;
    } t_push;

endpackage

// ----- src/rrfp_front.sv -----
// Front parser: hunts for reply frames, checks the checksum and classifies frames.
// Pushes one record per frame that yields a result. Depends on rrfp_pkg.
module rrfp_front #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    output logic          o_ready,
    input  logic          i_q_full,
    output rrfp_pkg::t_push o_push
);
    import rrfp_pkg::*;

    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_BODY = 5'b01000,
        PH_SUM  = 5'b10000
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_pos, n_pos;
    logic [7:0]    r_sum, n_sum;
    logic [7:0]    r_head [HEAD_BYTES];

    logic w_take;
    logic w_is_long;
    logic w_keep;

    // Only the checksum byte can need room in the queue.
    assign o_ready = !((r_phase == PH_SUM) && i_q_full);
    assign w_take  = i_valid && o_ready;

    assign w_is_long = (r_len >= LW'(HEAD_BYTES));
    assign w_keep    = (r_len >= LW'(2)) && (r_head[0] == DEVICE_CODE)
                       && !((r_head[1] == CMD_SELF_TEST) && !w_is_long);

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_pos   = r_pos;
        n_sum   = r_sum;
        o_push.push = 1'b0;
        o_push.rec  = '{is_long: w_is_long, b5: r_head[5], b4: r_head[4],
                        b3: r_head[3], b2: r_head[2], cmd: r_head[1]};
        if (w_take) begin
            unique case (r_phase)
                PH_HDR0: begin
                    if (i_byte == HDR0_BYTE) n_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    n_phase = (i_byte == HDR1_BYTE) ? PH_LEN : PH_HDR0;
                end
                PH_LEN: begin
                    n_len = LW'(i_byte);
                    n_pos = '0;
                    n_sum = '0;
                    n_phase = ((i_byte != 8'd0) && (i_byte <= MAX_LEN)) ? PH_BODY : PH_HDR0;
                end
                PH_BODY: begin
                    n_sum = r_sum + i_byte;
                    n_pos = r_pos + LW'(1);
                    if (n_pos >= r_len) n_phase = PH_SUM;
                end
                PH_SUM: begin
                    o_push.push = (r_sum == i_byte) && w_keep;
                    n_phase = PH_HDR0;
                    n_len   = '0;
                    n_pos   = '0;
                    n_sum   = '0;
                end
                default: begin
                    n_phase = PH_HDR0;
                    n_len   = '0;
                    n_pos   = '0;
                    n_sum   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_len   <= '0;
            r_pos   <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
        end
    end

    // Head bytes are only read from the frame that wrote them.
    always_ff @(posedge i_clk) begin
        if (w_take && (r_phase == PH_BODY)) begin
            for (int i = 0; i < HEAD_BYTES; i++) begin
                if (r_pos == LW'(i)) r_head[i] <= i_byte;
            end
        end
    end

endmodule

// ----- src/rrfp_queue.sv -----
// Short record queue between the front parser and the back decoder.
// Depends on rrfp_pkg for the record type and depth.
module rrfp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrfp_pkg::t_push      i_push,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_not_empty,
    output rrfp_pkg::t_frame_rec o_rec
);
    import rrfp_pkg::*;

    localparam int IW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_frame_rec    r_mem [Q_DEPTH];
    logic [IW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full      = (r_cnt == CW'(Q_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_rec       = r_mem[r_rd];

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] p);
        f_next = (p == IW'(Q_DEPTH - 1)) ? '0 : p + IW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push.push && !o_full) r_mem[r_wr] <= i_push.rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push && !o_full) r_wr <= f_next(r_wr);
            if (i_pop && o_not_empty) r_rd <= f_next(r_rd);
            case ({i_push.push && !o_full, i_pop && o_not_empty})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/rrfp_back.sv -----
// Back decoder: turns a frame record into a result and holds it in the output register.
// Depends on rrfp_pkg.
module rrfp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_not_empty,
    input  rrfp_pkg::t_frame_rec i_rec,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rrfp_pkg::t_result    o_result
);
    import rrfp_pkg::*;

    logic       r_valid;
    t_result    r_result, n_result;
    logic [3:0] w_nib;
    logic [15:0] w_meters;
    logic       w_ok;
    logic [DIST_W-1:0] w_dist;

    assign o_pop    = i_q_not_empty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    assign w_nib    = 4'(i_rec.b2 & NIBBLE_MASK);
    assign w_meters = {i_rec.b3, i_rec.b4};
    assign w_ok     = (w_nib <= NIB_LAST) && (w_meters != METERS_INVALID);
    assign w_dist   = DIST_W'(w_meters) * DIST_W'(MM_PER_METER)
                    + DIST_W'(i_rec.b5) * DIST_W'(MM_PER_TENTH);

    always_comb begin
        n_result = '0;
        n_result.reply_command = i_rec.cmd;
        unique case (i_rec.cmd) inside
            CMD_SELF_TEST: begin
                n_result.data_valid       = 1'b1;
                n_result.status_byte      = i_rec.b5;
                n_result.self_status_word = {i_rec.b5, i_rec.b4, i_rec.b3, i_rec.b2};
                n_result.self_test_pass   = i_rec.b4[0] & i_rec.b5[0];
            end
            CMD_MEASURE, CMD_CONTINUOUS: begin
                if (i_rec.is_long) begin
                    n_result.data_valid      = 1'b1;
                    n_result.status_byte     = i_rec.b2;
                    n_result.target_number   = i_rec.b2[7:4];
                    n_result.target_ok       = w_ok;
                    n_result.first_target_ok = w_ok && (w_nib == NIB_FIRST);
                    n_result.last_target_ok  = w_ok && (w_nib == NIB_LAST);
                    n_result.dist_mm         = w_ok ? w_dist : '0;
                    n_result.continuous_mode = (i_rec.cmd == CMD_CONTINUOUS);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_result <= n_result;
    end

endmodule

// ----- src/range_reply_frame_parser.sv -----
// Rangefinder reply frame parser, top level. Depends on rrfp_pkg, rrfp_front,
// rrfp_queue and rrfp_back.
// Throughput: one received byte per cycle; the input stalls only on a checksum byte
// while the two-entry record queue is full.
// Path: once its checksum byte is accepted, a result is written into the record queue
// and from there into the output register, which drives the master side.
// Reset: synchronous, active low; the parser returns to hunting for a header and the
// queue and output register empty. Stored payload bytes are not cleared.
module range_reply_frame_parser #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] reply_command, [8] data_valid, [16:9] status_byte,
    // [48:17] self_status_word, [49] self_test_pass, [53:50] target_number,
    // [54] target_ok, [55] first_target_ok, [56] last_target_ok,
    // [82:57] dist_mm, [83] continuous_mode, [87:84] zero
    output logic [rrfp_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import rrfp_pkg::*;

    t_push      w_push;
    t_frame_rec w_q_rec;
    t_result    w_result;
    logic       w_q_full;
    logic       w_q_not_empty;
    logic       w_pop;

    // The front parser walks the frame layout one byte per request and decides,
    // at the checksum byte, whether the frame produces a result at all.
    rrfp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_byte   (i_s_tdata),
        .o_ready  (o_s_tready),
        .i_q_full (w_q_full),
        .o_push   (w_push)
    );

    // The queue lets the parser keep taking bytes while a result waits downstream.
    rrfp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_pop       (w_pop),
        .o_full      (w_q_full),
        .o_not_empty (w_q_not_empty),
        .o_rec       (w_q_rec)
    );

    // The back decoder computes the fields, including the distance multiply,
    // and registers the result.
    rrfp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (w_q_not_empty),
        .i_rec         (w_q_rec),
        .o_pop         (w_pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_result      (w_result)
    );

    assign o_m_tdata = {(OUT_TDATA_W - $bits(t_result))'(0), w_result};

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push.push && w_q_full))
        else $error("record pushed into a full queue");

    a_push_fills_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push |=> w_q_not_empty)
        else $error("pushed record not visible in queue");

    a_pop_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (!o_m_tvalid || i_m_tready))
        else $error("result register overwritten while held");

    a_invalid_is_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !w_result.data_valid) |->
            (w_result.dist_mm == '0 && w_result.status_byte == '0
             && w_result.self_status_word == '0))
        else $error("command-only result carries data");
`endif

endmodule

// ----- tb/tb_range_reply_frame_parser.sv -----
// Self-checking testbench for the rangefinder reply frame parser.
// Holds a reply_checker class that predicts decoded replies from the received byte stream.
// Depends on rrfp_pkg and range_reply_frame_parser.
`timescale 1ns / 1ps

module tb_range_reply_frame_parser;
    import rrfp_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int MAX_LEN        = 16;
    localparam int TARGET_BYTES   = 1050;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    typedef logic [7:0] t_byte_q[$];

    // Where the parser stands in the byte stream.
    typedef enum logic [2:0] {
        HUNT_SYNC,
        HUNT_ID,
        TAKE_LEN,
        TAKE_PAYLOAD,
        TAKE_CSUM
    } t_parse_state;

    // Tracks the frame parse alongside the block and keeps the replies it owes us.
    class reply_checker;
        t_parse_state state;
        int unsigned  max_len;
        int unsigned  frame_len;
        int unsigned  pos;
        logic [7:0]   csum;
        logic [7:0]   head [HEAD_BYTES];
        t_result      expected_replies[$];
        int unsigned  errors;
        int unsigned  replies_seen;
        int unsigned  frames_clean;
        int unsigned  decoded_owed;

        function new(int unsigned limit);
            max_len      = limit;
            state        = HUNT_SYNC;
            frame_len    = 0;
            pos          = 0;
            csum         = '0;
            errors       = 0;
            replies_seen = 0;
            frames_clean = 0;
            decoded_owed = 0;
        endfunction

        // Decodes the frame just closed; returns 1 when it yields a reply.
        function bit decode_reply(output t_result r);
            logic [7:0]  cmd;
            logic [7:0]  st;
            logic [3:0]  nib;
            logic [15:0] meters;
            bit          ok;
            int unsigned mm;
            r = '0;
            if (frame_len < 2 || head[0] != DEVICE_CODE) return 0;
            cmd = head[1];
            r.reply_command = cmd;
            if (cmd == CMD_SELF_TEST) begin
                if (frame_len < HEAD_BYTES) return 0;
                r.data_valid       = 1'b1;
                r.status_byte      = head[5];
                r.self_status_word = {head[5], head[4], head[3], head[2]};
                r.self_test_pass   = head[4][0] & head[5][0];
                return 1;
            end
            // Unknown commands and short measurement replies echo the command only.
            if ((cmd != CMD_MEASURE && cmd != CMD_CONTINUOUS) || frame_len < HEAD_BYTES)
                return 1;
            st     = head[2];
            nib    = st[3:0];
            meters = {head[3], head[4]};
            ok     = (nib <= NIB_LAST) && (meters != METERS_INVALID);
            mm     = 32'(meters) * 32'(MM_PER_METER) + 32'(head[5]) * 32'(MM_PER_TENTH);
            r.data_valid      = 1'b1;
            r.status_byte     = st;
            r.target_number   = st[7:4];
            r.target_ok       = ok;
            r.first_target_ok = ok && (nib == NIB_FIRST);
            r.last_target_ok  = ok && (nib == NIB_LAST);
            r.dist_mm         = ok ? DIST_W'(mm) : '0;
            r.continuous_mode = (cmd == CMD_CONTINUOUS);
            return 1;
        endfunction

        // Advances the parse by one accepted byte and queues any reply it causes.
        function void predict_rx_byte(logic [7:0] b);
            t_result r;
            case (state)
                HUNT_SYNC: begin
                    if (b == HDR0_BYTE) state = HUNT_ID;
                end
                HUNT_ID: begin
                    // A wrong second byte is not looked at again as a sync byte.
                    state = (b == HDR1_BYTE) ? TAKE_LEN : HUNT_SYNC;
                end
                TAKE_LEN: begin
                    frame_len = 32'(b);
                    pos       = 0;
                    csum      = '0;
                    state     = (b != 0 && b <= max_len) ? TAKE_PAYLOAD : HUNT_SYNC;
                end
                TAKE_PAYLOAD: begin
                    if (pos < HEAD_BYTES) head[pos] = b;
                    csum = csum + b;
                    pos++;
                    if (pos >= frame_len) state = TAKE_CSUM;
                end
                default: begin
                    if (csum == b) begin
                        frames_clean++;
                        if (decode_reply(r)) begin
                            expected_replies.push_back(r);
                            if (r.data_valid) decoded_owed++;
                        end
                    end
                    state     = HUNT_SYNC;
                    frame_len = 0;
                    pos       = 0;
                    csum      = '0;
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v)
                report($sformatf("reply %0d: %s is %0h, expected %0h",
                                 replies_seen, name, got_v, want_v));
        endtask

        task check_reply(t_result got);
            t_result want;
            replies_seen++;
            if (expected_replies.size() == 0) begin
                report($sformatf("reply %0d (command %02h) arrived with none pending",
                                 replies_seen, got.reply_command));
                return;
            end
            want = expected_replies.pop_front();
            compare_field("reply_command",    32'(got.reply_command),
                          32'(want.reply_command));
            compare_field("data_valid",       32'(got.data_valid),
                          32'(want.data_valid));
            compare_field("status_byte",      32'(got.status_byte),
                          32'(want.status_byte));
            compare_field("self_status_word", got.self_status_word,
                          want.self_status_word);
            compare_field("self_test_pass",   32'(got.self_test_pass),
                          32'(want.self_test_pass));
            compare_field("target_number",    32'(got.target_number),
                          32'(want.target_number));
            compare_field("target_ok",        32'(got.target_ok),
                          32'(want.target_ok));
            compare_field("first_target_ok",  32'(got.first_target_ok),
                          32'(want.first_target_ok));
            compare_field("last_target_ok",   32'(got.last_target_ok),
                          32'(want.last_target_ok));
            compare_field("dist_mm",          32'(got.dist_mm),
                          32'(want.dist_mm));
            compare_field("continuous_mode",  32'(got.continuous_mode),
                          32'(want.continuous_mode));
        endtask
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata  = '0;    // [7:0] rx_byte
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [7:0] reply_command, [8] data_valid, [16:9] status_byte, [48:17] self_status_word,
    // [49] self_test_pass, [53:50] target_number, [54] target_ok, [55] first_target_ok,
    // [56] last_target_ok, [82:57] dist_mm, [83] continuous_mode, [87:84] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    reply_checker sb;
    int unsigned  src_idle    = 38;
    int unsigned  sink_idle   = 77;
    int unsigned  bytes_sent  = 0;
    int unsigned  idle_cycles = 0;

    range_reply_frame_parser #(
        .MAX_PAYLOAD(MAX_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // The reply side stalls at random; the rate follows the current phase.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_idle);
    end

    // Every reply taken from the block is checked against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_reply(t_result'(o_m_tdata[$bits(t_result)-1:0]));
    end

    // Ends the run if neither side moves a request for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[%0t] Watchdog: no request moved for %0d cycles",
                     $realtime, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one received byte, with random idle cycles ahead of it, and waits until
    // the block takes it. The idling pattern changes with the phase of the run.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        sb.predict_rx_byte(b);
        bytes_sent++;
        if (bytes_sent == TARGET_BYTES / 3) begin
            src_idle  = 77;
            sink_idle = 38;
        end else if (bytes_sent == 2 * TARGET_BYTES / 3) begin
            src_idle  = 0;
            sink_idle = 0;
        end
        @(negedge i_clk);
    endtask

    // Payload of n bytes: device code, command, status, meters high and low, tenths,
    // then random filler that only feeds the checksum.
    function automatic t_byte_q build_payload(int unsigned n, logic [7:0] dev,
            logic [7:0] cmd, logic [7:0] st, logic [15:0] meters, logic [7:0] tenths);
        t_byte_q    q;
        logic [7:0] lead [HEAD_BYTES];
        lead = '{dev, cmd, st, meters[15:8], meters[7:0], tenths};
        for (int k = 0; k < n; k++) q.push_back(k < HEAD_BYTES ? lead[k] : 8'($urandom));
        return q;
    endfunction

    // Sends header, length field, payload and checksum. The length field may disagree
    // with the payload, and the checksum may be spoiled by one flipped bit.
    task automatic send_frame(input int unsigned n, input logic [7:0] len_field,
            input bit corrupt, input logic [7:0] dev, input logic [7:0] cmd,
            input logic [7:0] st, input logic [15:0] meters, input logic [7:0] tenths);
        t_byte_q    body;
        logic [7:0] sum;
        body = build_payload(n, dev, cmd, st, meters, tenths);
        sum  = '0;
        push_byte(HDR0_BYTE);
        push_byte(HDR1_BYTE);
        push_byte(len_field);
        foreach (body[k]) begin
            push_byte(body[k]);
            sum = sum + body[k];
        end
        push_byte(corrupt ? (sum ^ 8'(1 << $urandom_range(7))) : sum);
    endtask

    task automatic send_random_sequence();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  dev;
        logic [7:0]  cmd;
        logic [7:0]  st;
        logic [15:0] meters;
        pick   = $urandom_range(99);
        n      = ($urandom_range(3) == 0) ? $urandom_range(1, 5)
                                          : $urandom_range(HEAD_BYTES, MAX_LEN);
        dev    = ($urandom_range(9) == 0) ? 8'($urandom) : DEVICE_CODE;
        case ($urandom_range(5))
            0:       cmd = CMD_SELF_TEST;
            1, 2:    cmd = CMD_MEASURE;
            3:       cmd = CMD_CONTINUOUS;
            default: cmd = 8'($urandom);
        endcase
        // Keep the status nibble mostly in the valid range so targets decode.
        st     = {4'($urandom), ($urandom_range(3) == 0) ? 4'($urandom)
                                                         : 4'($urandom_range(2))};
        meters = ($urandom_range(7) == 0) ? METERS_INVALID : 16'($urandom);
        if (pick < 75) begin
            send_frame(n, 8'(n), ($urandom_range(9) == 0), dev, cmd, st, meters,
                       8'($urandom));
        end else if (pick < 85) begin
            // Line noise, sometimes a sync byte followed by the wrong second byte.
            if ($urandom_range(1) == 0) begin
                push_byte(HDR0_BYTE);
                push_byte(8'($urandom));
            end
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
        end else if (pick < 92) begin
            // Length field of zero or above the limit; the payload becomes noise.
            send_frame(n, ($urandom_range(2) == 0) ? 8'h00
                          : 8'($urandom_range(MAX_LEN + 1, 255)),
                       1'b0, dev, cmd, st, meters, 8'($urandom));
        end else begin
            // Length field that does not match the bytes that follow.
            send_frame(n, 8'($urandom_range(1, MAX_LEN)), 1'b0, dev, cmd, st, meters,
                       8'($urandom));
        end
    endtask

    initial begin
        sb = new(MAX_LEN);
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames: decode paths, field extremes and every way a frame is dropped.
        send_frame(6, 8'd6, 1'b0, DEVICE_CODE, CMD_MEASURE, 8'h01, 16'h0000, 8'h00);
        send_frame(16, 8'd16, 1'b0, DEVICE_CODE, CMD_CONTINUOUS, 8'hF2, 16'hFFFE, 8'hFF);
        send_frame(6, 8'd6, 1'b0, DEVICE_CODE, CMD_CONTINUOUS, 8'h41, 16'hFFFE, 8'hFF);
        send_frame(6, 8'd6, 1'b0, DEVICE_CODE, CMD_MEASURE, 8'h10, METERS_INVALID, 8'h05);
        send_frame(7, 8'd7, 1'b0, DEVICE_CODE, CMD_CONTINUOUS, 8'h03, 16'h1234, 8'h09);
        send_frame(6, 8'd6, 1'b0, DEVICE_CODE, CMD_SELF_TEST, 8'hA5, 16'h5A01, 8'h81);
        send_frame(9, 8'd9, 1'b0, DEVICE_CODE, CMD_SELF_TEST, 8'hFF, 16'hFFFE, 8'hFF);
        // Short self-test gives nothing; short measurement echoes only the command.
        send_frame(5, 8'd5, 1'b0, DEVICE_CODE, CMD_SELF_TEST, 8'h11, 16'h0101, 8'h01);
        send_frame(5, 8'd5, 1'b0, DEVICE_CODE, CMD_MEASURE, 8'h01, 16'h0010, 8'h02);
        send_frame(2, 8'd2, 1'b0, DEVICE_CODE, 8'h07, 8'h00, 16'h0000, 8'h00);
        send_frame(6, 8'd6, 1'b0, DEVICE_CODE, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_frame(6, 8'd6, 1'b0, DEVICE_CODE, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_frame(1, 8'd1, 1'b0, DEVICE_CODE, CMD_MEASURE, 8'h01, 16'h0001, 8'h01);
        send_frame(6, 8'd6, 1'b0, 8'h02, CMD_MEASURE, 8'h01, 16'h0001, 8'h01);
        send_frame(6, 8'd6, 1'b1, DEVICE_CODE, CMD_MEASURE, 8'h01, 16'h0001, 8'h01);
        push_byte(HDR0_BYTE);
        push_byte(8'h15);
        // A stray sync byte swallows the next frame's sync byte: no resync.
        push_byte(HDR0_BYTE);
        send_frame(6, 8'd6, 1'b0, DEVICE_CODE, CMD_MEASURE, 8'h02, 16'h0002, 8'h02);
        send_frame(6, 8'h00, 1'b0, DEVICE_CODE, CMD_MEASURE, 8'h01, 16'h0003, 8'h03);
        send_frame(4, 8'(MAX_LEN + 1), 1'b0, DEVICE_CODE, CMD_MEASURE, 8'h01, 16'h0004, 8'h04);
        send_frame(3, 8'hFF, 1'b0, DEVICE_CODE, CMD_MEASURE, 8'h01, 16'h0005, 8'h05);
        send_frame(6, 8'd6, 1'b0, DEVICE_CODE, CMD_MEASURE, 8'h22, 16'h0BB8, 8'h07);

        while (bytes_sent < TARGET_BYTES) send_random_sequence();
        i_s_tvalid <= 1'b0;

        while (sb.expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes; %0d frames passed the checksum.",
                 bytes_sent, sb.frames_clean);
        $display("Checked %0d replies, %0d of them with decoded data.",
                 sb.replies_seen, sb.decoded_owed);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
